>>> src/polyphonic_wavetable_voice_mixer_macros.svh
// Assertion helpers used by the bound checker, pwvm_checker.
// Both forms sample on the rising edge of clk and are off while rst_n is low.
`ifndef POLYPHONIC_WAVETABLE_VOICE_MIXER_MACROS_SVH
`define POLYPHONIC_WAVETABLE_VOICE_MIXER_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define PWVM_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define PWVM_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> src/pwvm_pkg.sv
`default_nettype none

package pwvm_pkg;

    // TABLE_SIZE must be a power of two of at least 16.
    localparam int TABLE_SIZE = 1024;
    localparam int VOICES     = 15;

    localparam int FRAC_W   = 16;
    localparam int IDX_W    = $clog2(TABLE_SIZE);
    localparam int QIDX_W   = IDX_W - 2;
    localparam int QUARTER  = TABLE_SIZE / 4;
    localparam int PHASE_W  = IDX_W + FRAC_W;
    localparam int STEP_W   = 26;
    localparam int KEY_W    = 7;
    localparam int VEL_W    = 7;
    localparam int VOL_W    = VEL_W - 3;
    localparam int ROM_W    = 12;
    localparam int SAMPLE_W = 16;
    localparam int KIND_W   = 2;

    localparam int IN_BITS  = KEY_W + VEL_W + STEP_W;
    localparam int S_DATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam int ROM_MAX  = 4095;
    localparam int VOL_MAX  = 15;
    localparam int ACC_W    = $clog2(VOICES * ROM_MAX * VOL_MAX + 1);
    localparam int CNT_W    = (VOICES > 1) ? $clog2(VOICES) : 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK = 2'd0,
        KIND_ON   = 2'd1,
        KIND_OFF  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [STEP_W-1:0]  inc;
        logic [KEY_W-1:0]   key;
        logic [VOL_W-1:0]   vol;
    } voice_t;

    // Note event held by the control for the length of one pass around the ring.
    typedef struct packed {
        kind_t              op;
        logic [KEY_W-1:0]   key;
        logic [VOL_W-1:0]   vol;
        logic [STEP_W-1:0]  step;
        logic               found;
    } voice_cmd_t;

endpackage

`default_nettype wire

>>> src/pwvm_cell.sv
`default_nettype none

module pwvm_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  pwvm_pkg::voice_t din,
    output pwvm_pkg::voice_t dout
);
    import pwvm_pkg::*;

    voice_t voice_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_reg <= '0;
        end
        else if (shift)
        begin
            voice_reg <= din;
        end
    end

    assign dout = voice_reg;

endmodule

`default_nettype wire

>>> src/pwvm_voice_alu.sv
`default_nettype none

module pwvm_voice_alu (
    input  pwvm_pkg::voice_cmd_t cmd,
    input  pwvm_pkg::voice_t     rec_in,
    output pwvm_pkg::voice_t     rec_out,
    output logic                 hit
);
    import pwvm_pkg::*;

    localparam int SUM_W = ((PHASE_W > STEP_W) ? PHASE_W : STEP_W) + 1;

    logic [SUM_W-1:0] phase_sum;

    // The wrap limit is a power of two, so dropping the carry is the modulo.
    assign phase_sum = SUM_W'(rec_in.phase) + SUM_W'(rec_in.inc);

    always_comb
    begin
        rec_out = rec_in;
        hit     = 1'b0;
        case (cmd.op)
            KIND_TICK:
            begin
                rec_out.phase = phase_sum[PHASE_W-1:0];
            end
            KIND_ON:
            begin
                if (!cmd.found && rec_in.inc == '0)
                begin
                    rec_out.inc = cmd.step;
                    rec_out.key = cmd.key;
                    rec_out.vol = cmd.vol;
                    hit         = 1'b1;
                end
            end
            KIND_OFF:
            begin
                if (!cmd.found && rec_in.inc != '0 && rec_in.key == cmd.key)
                begin
                    rec_out = '0;
                    hit     = 1'b1;
                end
            end
            default:
            begin
                rec_out = rec_in;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/pwvm_sine_lut.sv
`default_nettype none

module pwvm_sine_lut (
    input  logic [pwvm_pkg::IDX_W-1:0] idx,
    output logic [pwvm_pkg::ROM_W-1:0] value
);
    import pwvm_pkg::*;

    localparam logic [63:0] Q_ONE     = 64'h4000000000000000;
    localparam logic [63:0] Q_HALF_PI = 64'h6487ED5110B4611A;
    localparam logic [63:0] LOW31     = 64'h000000007FFFFFFF;
    localparam logic [63:0] STEP_Q    = Q_HALF_PI >> IDX_W;
    localparam logic [63:0] STEP_R    = Q_HALF_PI & 64'(TABLE_SIZE - 1);

    // Each entry holds the magnitude of one quarter-wave sample and a flag
    // that is set when the magnitude had a fractional part.
    typedef logic [ROM_W-1:0] qtab_t [QUARTER];

    function automatic logic [63:0] q_mul(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[125:62];
    endfunction

    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem    = rem - {1'b0, d};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Taylor series of sine or cosine in Q2.62 for angles below a quarter turn.
    function automatic logic [63:0] q_trig(input logic [63:0] a, input logic want_cos);
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] d;
        a2   = q_mul(a, a);
        term = want_cos ? Q_ONE : a;
        pos  = term;
        neg  = '0;
        for (int k = 1; k <= 13; k++)
        begin
            d    = want_cos ? 64'((2 * k - 1) * (2 * k)) : 64'((2 * k) * (2 * k + 1));
            term = udiv(q_mul(term, a2), d);
            if (k[0])
            begin
                neg = neg + term;
            end
            else
            begin
                pos = pos + term;
            end
        end
        return (pos > neg) ? (pos - neg) : 64'd0;
    endfunction

    function automatic logic [ROM_W-1:0] entry(input int j, input logic want_cos);
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] s;
        logic [63:0] sh;
        logic [63:0] sl;
        logic [63:0] p;
        logic [63:0] hi;
        logic [63:0] whole;
        logic        frac;
        r     = 64'(4 * j);
        a     = STEP_Q * r + ((STEP_R * r) >> IDX_W);
        s     = q_trig(a, want_cos);
        sh    = s >> 31;
        sl    = s & LOW31;
        p     = 64'd2047 * sl;
        hi    = 64'd2047 * sh + (p >> 31);
        whole = hi >> 31;
        frac  = ((hi & LOW31) != 64'd0) || ((p & LOW31) != 64'd0);
        return {frac, whole[ROM_W-2:0]};
    endfunction

    function automatic qtab_t build(input logic want_cos);
        qtab_t t;
        for (int j = 0; j < QUARTER; j++)
        begin
            t[j] = entry(j, want_cos);
        end
        return t;
    endfunction

    localparam qtab_t SIN_TAB = build(1'b0);
    localparam qtab_t COS_TAB = build(1'b1);

    logic [1:0]        quad;
    logic [QIDX_W-1:0] qidx;
    logic [ROM_W-1:0]  ent;
    logic [ROM_W-1:0]  mag;
    logic [ROM_W-1:0]  frac_bit;

    assign quad     = idx[IDX_W-1:IDX_W-2];
    assign qidx     = idx[QIDX_W-1:0];
    // Odd quadrants take the cosine series of the same offset.
    assign ent      = quad[0] ? COS_TAB[qidx] : SIN_TAB[qidx];
    assign mag      = {1'b0, ent[ROM_W-2:0]};
    assign frac_bit = {{(ROM_W-1){1'b0}}, ent[ROM_W-1]};

    // The negative half rounds toward minus infinity, hence the extra one.
    assign value = quad[1] ? (12'd2048 - mag - frac_bit) : (12'd2048 + mag);

endmodule

`default_nettype wire

>>> src/polyphonic_wavetable_voice_mixer.sv
// Every note or tick item runs the voice ring once: accept in IDLE, rotation in RUN, one flush.
// No new item is taken until the last has finished its pass; an unused kind is dropped on accept.
// A sample tick then passes EMIT, and its sample shows on m_tvalid as the control returns to IDLE
// to take the next item. The pace is set by the single voice update cell that each voice passes
// once per item. A stalled earlier sample holds the tick until it leaves.
// rst_n (asynchronous, active low) clears all voices and the control; the sine table is constant.
`default_nettype none

module polyphonic_wavetable_voice_mixer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // key [6:0], velocity [13:7], phase_step [39:14]
    input  logic [pwvm_pkg::S_DATA_W-1:0]   s_tdata,
    // kind [1:0]
    input  logic [pwvm_pkg::KIND_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // sample [15:0]
    output logic [pwvm_pkg::SAMPLE_W-1:0]   m_tdata
);
    import pwvm_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        RUN,
        FLUSH,
        EMIT
    } state_t;

    localparam logic [ACC_W-1:0] SAT_MAX = ACC_W'(17'h0FFFF);

    state_t                    state_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      found_reg;
    logic                      pv_reg;
    logic                      m_tvalid_reg;

    kind_t                     op_reg;
    logic [KEY_W-1:0]          key_reg;
    logic [VOL_W-1:0]          vol_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [ROM_W-1:0]          rom_reg;
    logic [VOL_W-1:0]          romvol_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [SAMPLE_W-1:0]       m_tdata_reg;

    logic [KEY_W-1:0]          in_key;
    logic [VEL_W-1:0]          in_vel;
    logic [STEP_W-1:0]         in_step;
    logic                      in_known;
    logic                      shift;
    logic                      hit;
    logic                      emit_ok;
    voice_cmd_t                cmd;
    voice_t                    chain [VOICES+1];
    logic [ROM_W-1:0]          rom_value;
    logic [ROM_W+VOL_W-1:0]    prod;
    logic [ACC_W-1:0]          mixed;
    logic [SAMPLE_W-1:0]       sample;

    assign in_key   = s_tdata[KEY_W-1:0];
    assign in_vel   = s_tdata[KEY_W+VEL_W-1:KEY_W];
    assign in_step  = s_tdata[IN_BITS-1:KEY_W+VEL_W];
    assign in_known = (s_tuser == KIND_TICK) || (s_tuser == KIND_ON) || (s_tuser == KIND_OFF);

    assign s_tready = (state_reg == IDLE);
    assign shift    = (state_reg == RUN);
    assign emit_ok  = !m_tvalid_reg || m_tready;

    assign cmd.op    = op_reg;
    assign cmd.key   = key_reg;
    assign cmd.vol   = vol_reg;
    assign cmd.step  = step_reg;
    assign cmd.found = found_reg;

    // Cell 0 is the voice under update; the updated voice re-enters at the far end,
    // so after VOICES shifts every voice is back in its own cell.
    generate
        for (genvar i = 0; i < VOICES; i++)
        begin : g_ring
            pwvm_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .din   (chain[i+1]),
                .dout  (chain[i])
            );
        end
    endgenerate

    pwvm_voice_alu u_alu (
        .cmd     (cmd),
        .rec_in  (chain[0]),
        .rec_out (chain[VOICES]),
        .hit     (hit)
    );

    pwvm_sine_lut u_lut (
        .idx   (chain[0].phase[PHASE_W-1:FRAC_W]),
        .value (rom_value)
    );

    assign prod   = rom_reg * romvol_reg;
    assign mixed  = acc_reg >> 4;
    assign sample = (mixed > SAT_MAX) ? {SAMPLE_W{1'b1}} : mixed[SAMPLE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            cnt_reg      <= '0;
            found_reg    <= 1'b0;
            pv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (s_tvalid && in_known)
                    begin
                        state_reg <= RUN;
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                        pv_reg    <= 1'b0;
                    end
                end
                RUN:
                begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    found_reg <= found_reg | hit;
                    pv_reg    <= (op_reg == KIND_TICK);
                    if (cnt_reg == CNT_W'(VOICES - 1))
                    begin
                        state_reg <= FLUSH;
                    end
                end
                FLUSH:
                begin
                    pv_reg    <= 1'b0;
                    state_reg <= (op_reg == KIND_TICK) ? EMIT : IDLE;
                end
                EMIT:
                begin
                    if (emit_ok)
                    begin
                        m_tdata_reg <= sample;
                        state_reg   <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
            if (state_reg == EMIT && emit_ok)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == IDLE && s_tvalid)
        begin
            op_reg   <= kind_t'(s_tuser);
            key_reg  <= in_key;
            vol_reg  <= in_vel[VEL_W-1:3];
            step_reg <= in_step;
            acc_reg  <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod);
        end
        if (shift)
        begin
            rom_reg    <= rom_value;
            romvol_reg <= chain[0].vol;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> src/pwvm_checker.sv
`default_nettype none
`include "polyphonic_wavetable_voice_mixer_macros.svh"

module pwvm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [pwvm_pkg::KIND_W-1:0]     s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pwvm_pkg::SAMPLE_W-1:0]   m_tdata
);
    import pwvm_pkg::*;

    logic in_take;
    logic in_event;
    logic in_tick;
    logic out_wait;
    logic ev_take;
    logic tick_idle;
    logic unused_take;

    assign in_take     = s_tvalid && s_tready;
    assign in_event    = (s_tuser == KIND_TICK) || (s_tuser == KIND_ON) || (s_tuser == KIND_OFF);
    assign in_tick     = (s_tuser == KIND_TICK);
    assign out_wait    = m_tvalid && !m_tready;
    assign ev_take     = in_take && in_event;
    assign tick_idle   = in_take && in_tick && !m_tvalid;
    assign unused_take = in_take && !in_event;

    // A waiting sample must not change or vanish.
    `PWVM_ASSERT_NEXT(a_out_hold, out_wait, m_tvalid && $stable(m_tdata), "sample not held")

    // A real event occupies the voice ring, so no second item may follow at once.
    `PWVM_ASSERT_NEXT(a_busy_after_take, ev_take, !s_tready, "item taken while ring busy")

    // A tick needs a full pass over the voices before its sample can appear.
    `PWVM_ASSERT_NEXT(a_no_early_sample, tick_idle, !m_tvalid, "sample too early")

    // An unused kind is dropped at once, so the input stays ready.
    `PWVM_ASSERT_NEXT(a_unused_drop, unused_take, s_tready, "ready dropped on unused kind")

endmodule

bind polyphonic_wavetable_voice_mixer pwvm_checker u_checker (.*);

`default_nettype wire

>>> tb/sv/pwvm_mixer_checker.sv
`timescale 1ns / 100ps

module pwvm_mixer_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // key [6:0], velocity [13:7], phase_step [39:14]
    input  logic [pwvm_pkg::S_DATA_W-1:0]   s_tdata,
    // kind [1:0]
    input  logic [pwvm_pkg::KIND_W-1:0]     s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // sample [15:0]
    input  logic [pwvm_pkg::SAMPLE_W-1:0]   m_tdata,
    output int                              mismatches,
    output int                              samples_due
);

    import pwvm_pkg::*;

    // Fixed-point constants for building the sine table: 1.0 and pi/2 in Q2.62.
    localparam logic [63:0] Q_ONE     = 64'h4000_0000_0000_0000;
    localparam logic [63:0] Q_HALF_PI = 64'h6487_ED51_10B4_611A;

    logic [PHASE_W-1:0] phase_acc [VOICES];
    logic [STEP_W-1:0]  step_of   [VOICES];
    logic [KEY_W-1:0]   key_of    [VOICES];
    logic [VOL_W-1:0]   vol_of    [VOICES];
    logic [ROM_W-1:0]   sine_rom  [TABLE_SIZE];

    logic [SAMPLE_W-1:0] mixed_samples [$];
    int                  sample_count;

    function automatic logic [63:0] fx_mul(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] prod;
        prod = {64'd0, x} * {64'd0, y};
        return prod[125:62];
    endfunction

    // The table is rebuilt with the same truncating series arithmetic as the block's
    // constant contents, so that entries close to an integer boundary agree exactly.
    initial
    begin : build_sine
        logic [63:0]  quad, rem, ang, ang2, term, pos, neg, div, tsz;
        logic [127:0] scaled;
        tsz = 64'(TABLE_SIZE);
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            quad = 64'(4 * i) / tsz;
            rem  = 64'(4 * i) - quad * tsz;
            ang  = (Q_HALF_PI / tsz) * rem + ((Q_HALF_PI % tsz) * rem) / tsz;
            ang2 = fx_mul(ang, ang);
            // Odd quadrants use the cosine of the remaining angle.
            term = quad[0] ? Q_ONE : ang;
            pos  = term;
            neg  = 64'd0;
            for (int k = 1; k <= 13; k++)
            begin
                div  = quad[0] ? 64'((2 * k - 1) * (2 * k)) : 64'((2 * k) * (2 * k + 1));
                term = fx_mul(term, ang2) / div;
                if (k % 2 == 1)
                    neg += term;
                else
                    pos += term;
            end
            term   = (pos > neg) ? pos - neg : 64'd0;
            scaled = {64'd0, term} * 128'd2047;
            if (quad < 64'd2)
                sine_rom[i] = ROM_W'(64'd2048 + scaled[127:62]);
            else
                sine_rom[i] = ROM_W'(64'd2048 - scaled[127:62]
                                     - 64'(scaled[61:0] != 62'd0));
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [SAMPLE_W-1:0] want;
        logic [KEY_W-1:0]    ev_key;
        logic [VEL_W-1:0]    ev_vel;
        logic [STEP_W-1:0]   ev_step;
        logic [63:0]         next_phase;
        logic [63:0]         phase_limit;
        logic [63:0]         mix;
        bit                  done;
        if (!rst_n)
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                phase_acc[v] = '0;
                step_of[v]   = '0;
                key_of[v]    = '0;
                vol_of[v]    = '0;
            end
            mixed_samples.delete();
            sample_count = 0;
            mismatches   = 0;
            samples_due <= 0;
        end
        else
        begin
            // Results are checked before this edge's input is applied: no input can
            // produce its sample in the same cycle.
            if (m_tvalid && m_tready)
            begin
                if (mixed_samples.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: sample %0d arrived with none pending: got %0d",
                                 $realtime, sample_count, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = mixed_samples.pop_front();
                    if (m_tdata !== want)
                    begin
                        if (mismatches < 10)
                            $display("%0t: sample %0d: expected %0d, got %0d",
                                     $realtime, sample_count, want, m_tdata);
                        mismatches++;
                    end
                end
                sample_count++;
            end

            if (s_tvalid && s_tready)
            begin
                ev_key  = s_tdata[KEY_W-1:0];
                ev_vel  = s_tdata[KEY_W +: VEL_W];
                ev_step = s_tdata[KEY_W+VEL_W +: STEP_W];
                done    = 1'b0;
                case (s_tuser)
                    KIND_ON:
                    begin
                        // A zero step loads key and volume but leaves the voice free.
                        for (int v = 0; v < VOICES; v++)
                        begin
                            if (!done && step_of[v] == '0)
                            begin
                                step_of[v] = ev_step;
                                key_of[v]  = ev_key;
                                vol_of[v]  = ev_vel[VEL_W-1:3];
                                done       = 1'b1;
                            end
                        end
                    end
                    KIND_OFF:
                    begin
                        for (int v = 0; v < VOICES; v++)
                        begin
                            if (!done && step_of[v] != '0 && key_of[v] == ev_key)
                            begin
                                phase_acc[v] = '0;
                                step_of[v]   = '0;
                                key_of[v]    = '0;
                                vol_of[v]    = '0;
                                done         = 1'b1;
                            end
                        end
                    end
                    KIND_TICK:
                    begin
                        phase_limit = 64'(TABLE_SIZE) << FRAC_W;
                        mix         = 64'd0;
                        for (int v = 0; v < VOICES; v++)
                        begin
                            mix += 64'(sine_rom[phase_acc[v][PHASE_W-1:FRAC_W]])
                                   * 64'(vol_of[v]);
                            next_phase = 64'(phase_acc[v]) + 64'(step_of[v]);
                            if (next_phase >= phase_limit)
                                next_phase -= phase_limit;
                            if (next_phase >= phase_limit)
                                next_phase %= phase_limit;
                            phase_acc[v] = next_phase[PHASE_W-1:0];
                        end
                        mix >>= 4;
                        if (mix > 64'hFFFF)
                            mix = 64'hFFFF;
                        mixed_samples.push_back(mix[SAMPLE_W-1:0]);
                    end
                    default: ;
                endcase
            end
            samples_due <= mixed_samples.size();
        end
    end

endmodule

>>> tb/sv/tb_polyphonic_wavetable_voice_mixer.sv
`timescale 1ns / 100ps

module tb_polyphonic_wavetable_voice_mixer;

    import pwvm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [STEP_W-1:0] STEP_MAX    = {STEP_W{1'b1}};

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic [KIND_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;

    int                    mismatches;
    int                    samples_due;
    int                    send_idle  = 0;
    int                    sink_stall = 0;
    logic [KEY_W-1:0]      held_keys [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    polyphonic_wavetable_voice_mixer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pwvm_mixer_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .samples_due (samples_due)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall);

    task automatic send_event(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                              input logic [VEL_W-1:0] vel, input logic [STEP_W-1:0] step);
        while (send_idle != 0 && $urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_DATA_W'({step, vel, key});
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Keys come mostly from a narrow range so that duplicates occur, and note-offs
    // mostly name a key that was played, so the voice pool fills and drains.
    task automatic random_event();
        int               pick;
        logic [KEY_W-1:0] key;
        logic [VEL_W-1:0] vel;
        logic [STEP_W-1:0] step;
        pick = $urandom_range(99);
        key  = ($urandom_range(3) == 0) ? KEY_W'($urandom_range(127))
                                        : KEY_W'($urandom_range(15));
        vel  = VEL_W'($urandom_range(127));
        case ($urandom_range(9))
            0:       step = '0;
            1, 2, 3: step = STEP_W'($urandom_range(STEP_MAX));
            default: step = STEP_W'($urandom_range(24'hFF_FFFF, 1));
        endcase
        if (pick < 45)
            send_event(KIND_TICK, key, vel, step);
        else if (pick < 75)
        begin
            send_event(KIND_ON, key, vel, step);
            held_keys.push_back(key);
            if (held_keys.size() > 32)
                void'(held_keys.pop_front());
        end
        else if (pick < 95)
        begin
            if (held_keys.size() != 0 && $urandom_range(3) != 0)
                key = held_keys[$urandom_range(held_keys.size() - 1)];
            send_event(KIND_OFF, key, vel, step);
        end
        else
            send_event(KIND_UNUSED, key, vel, step);
    endtask

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_event(KIND_TICK, 7'd0, 7'd0, '0);
        // The largest step wraps the phase on every tick after the first.
        send_event(KIND_ON, 7'd127, 7'd127, STEP_MAX);
        send_event(KIND_ON, 7'd0, 7'd0, 26'd1);
        // A zero step: the voice sounds at full volume yet stays free.
        send_event(KIND_ON, 7'd60, 7'd127, '0);
        send_event(KIND_TICK, 7'd0, 7'd0, '0);
        send_event(KIND_OFF, 7'd60, 7'd0, '0);
        send_event(KIND_ON, 7'd61, 7'd8, 26'h001_0000);
        send_event(KIND_TICK, 7'd0, 7'd0, '0);
        send_event(KIND_TICK, 7'd127, 7'd127, STEP_MAX);
        send_event(KIND_OFF, 7'd99, 7'd0, '0);
        send_event(KIND_OFF, 7'd0, 7'd0, '0);
        send_event(KIND_UNUSED, 7'd127, 7'd127, STEP_MAX);
        send_event(KIND_TICK, 7'd0, 7'd0, '0);
        send_event(KIND_ON, 7'd127, 7'd127, 26'h020_0000);
        // Two voices hold key 127; the lower one is released.
        send_event(KIND_OFF, 7'd127, 7'd0, '0);
        send_event(KIND_TICK, 7'd0, 7'd0, '0);
        send_event(KIND_ON, 7'd1, 7'd127, 26'h155_5555);
        send_event(KIND_ON, 7'd42, 7'd42, 26'h2AA_AAAA);
        send_event(KIND_TICK, 7'd85, 7'd85, 26'h155_5555);
        send_event(KIND_TICK, 7'd42, 7'd42, 26'h2AA_AAAA);
        send_event(KIND_TICK, 7'd0, 7'd0, '0);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle  = (phase == 1) ? 81 : (phase == 3) ? 27 : 0;
            sink_stall = (phase == 2) ? 81 : (phase == 3) ? 27 : 0;
            repeat (200) random_event();
        end
        s_tvalid <= 1'b0;
        sink_stall = 0;

        @(posedge clk);
        wait (samples_due == 0);
        // A trailing note item needs one pass around the voice ring.
        repeat (40) @(posedge clk);
        if (mismatches == 0 && samples_due == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> polyphonic_wavetable_voice_mixer.f
+incdir+src
src/pwvm_pkg.sv
src/pwvm_cell.sv
src/pwvm_voice_alu.sv
src/pwvm_sine_lut.sv
src/polyphonic_wavetable_voice_mixer.sv
src/pwvm_checker.sv
tb/sv/pwvm_mixer_checker.sv
tb/sv/tb_polyphonic_wavetable_voice_mixer.sv
